// ===== design/b3lwf_pkg.sv =====
// ----------------------------------------------------------------------------
// b3lwf_pkg: shared types, constants and helpers for the 3x3 LUT window filter
// Widths of the fixed fields, the stage-B item descriptor and the window shift.
// ----------------------------------------------------------------------------
package b3lwf_pkg;

  localparam int DEFAULT_MAX_WIDTH = 256;

  // configuration: eight 64-bit table words at byte address 8*i
  localparam int WORD_W     = 64;
  localparam int NUM_WORDS  = 8;
  localparam int CFG_ADDR_W = 6;
  localparam int TABLE_SIZE = NUM_WORDS * WORD_W;
  localparam int IDX_W      = 9;

  // counters
  localparam int                CNT_W      = 21;
  localparam logic [CNT_W-1:0]  COUNT_CAP  = CNT_W'(1 << 20);
  localparam int                ROW_W      = 2;
  localparam int                ON_COUNT_W = 17;
  localparam logic [ON_COUNT_W-1:0] LIT_CAP = '1;

  // line entry: bit 1 upper line, bit 0 middle line
  localparam int LINE_W = 2;

  typedef enum logic {
    KIND_PROC,
    KIND_FINAL
  } item_kind_t;

  // item handed from the control stage to the window stage
  typedef struct packed {
    logic       valid;
    item_kind_t kind;
    logic       px;
    logic       bg;
    logic       ic_zero;
    logic       in_range;
    logic       row_ge1;
    logic       row_ge2;
  } item_t;

  typedef struct packed {
    logic              en;
    logic [LINE_W-1:0] data;
  } line_wr_t;

  // shift a new column (bit 2 upper, bit 1 middle, bit 0 lower) in on the right
  function automatic logic [IDX_W-1:0] shift_col(input logic [IDX_W-1:0] w,
                                                 input logic [2:0] col);
    shift_col = {w[7:6], col[2], w[4:3], col[1], w[1:0], col[0]};
  endfunction

endpackage

// ===== design/b3lwf_if.sv =====
// ----------------------------------------------------------------------------
// b3lwf_if: stream channels of the 3x3 LUT window filter
// Raster input channel and result output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface b3lwf_raster_if;
  logic valid;
  logic ready;
  logic op;
  logic pixel_in;
  logic row_end;
  logic frame_end;

  modport source(output valid, op, pixel_in, row_end, frame_end, input ready);
  modport sink(input valid, op, pixel_in, row_end, frame_end, output ready);
endinterface

interface b3lwf_result_if;
  logic                              valid;
  logic                              ready;
  logic                              pixel_out;
  logic [b3lwf_pkg::ON_COUNT_W-1:0]  on_count;
  logic                              frame_last;

  modport source(output valid, pixel_out, on_count, frame_last, input ready);
  modport sink(input valid, pixel_out, on_count, frame_last, output ready);
endinterface

// ===== design/b3lwf_ram.sv =====
// ----------------------------------------------------------------------------
// b3lwf_ram: generic simple dual-port RAM
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module b3lwf_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== design/b3lwf_regs.sv =====
// ----------------------------------------------------------------------------
// b3lwf_regs: APB register file holding the 512-entry lookup table
// Eight 64-bit words; bit j of word k is table entry 64*k+j.
// ----------------------------------------------------------------------------
module b3lwf_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [b3lwf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [b3lwf_pkg::WORD_W-1:0]        pwdata,
  output logic [b3lwf_pkg::WORD_W-1:0]        prdata,
  output logic                                pready,
  output logic [b3lwf_pkg::TABLE_SIZE-1:0]    lut
);
  import b3lwf_pkg::*;

  logic [WORD_W-1:0] words [NUM_WORDS];
  logic [2:0]        sel;

  assign sel    = paddr[CFG_ADDR_W-1:3];
  assign pready = 1'b1;
  assign prdata = words[sel];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < NUM_WORDS; k++) begin
        words[k] <= '0;
      end
    end else if (psel && penable && pwrite) begin
      words[sel] <= pwdata;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_WORDS; k++) begin
      lut[k*WORD_W +: WORD_W] = words[k];
    end
  end

endmodule

// ===== design/b3lwf_ctrl.sv =====
// ----------------------------------------------------------------------------
// b3lwf_ctrl: raster tracking, line RAM access and flush sequencing
// Accepts beats, issues line reads, forwards same-entry writes, clears RAM.
// ----------------------------------------------------------------------------
module b3lwf_ctrl #(
  parameter int MAX_WIDTH = b3lwf_pkg::DEFAULT_MAX_WIDTH,
  localparam int AW = $clog2(MAX_WIDTH)
) (
  input  logic                              clk,
  input  logic                              rst,
  b3lwf_raster_if.sink                      raster,
  input  logic [1:0]                        table_ends,  // [0] entry 0, [1] entry 511
  input  logic                              advance,
  input  b3lwf_pkg::line_wr_t               line_wr,
  input  logic [b3lwf_pkg::LINE_W-1:0]      ram_rdata,
  output logic                              ram_re,
  output logic [AW-1:0]                     ram_raddr,
  output logic                              ram_we,
  output logic [AW-1:0]                     ram_waddr,
  output logic [b3lwf_pkg::LINE_W-1:0]      ram_wdata,
  output b3lwf_pkg::item_t                  item,
  output logic [b3lwf_pkg::LINE_W-1:0]      line_data
);
  import b3lwf_pkg::*;

  logic [CNT_W-1:0]  column_count, column_count_next;
  logic [CNT_W-1:0]  learned_width, learned_width_next;
  logic [ROW_W-1:0]  row_count, row_count_next;
  logic              background, background_next;
  logic              flushing, flushing_next;
  logic              clearing;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     b_addr;
  logic              fwd;
  logic [LINE_W-1:0] fwd_data;
  logic              accept;
  item_t             item_next;

  assign raster.ready = !clearing && advance;
  assign accept       = raster.valid && raster.ready;

  assign ram_re    = accept;
  assign ram_raddr = column_count[AW-1:0];
  assign ram_we    = clearing || line_wr.en;
  assign ram_waddr = clearing ? clr_addr : b_addr;
  assign ram_wdata = clearing ? '0 : line_wr.data;
  assign line_data = fwd ? fwd_data : ram_rdata;

  always_comb begin
    column_count_next  = column_count;
    learned_width_next = learned_width;
    row_count_next     = row_count;
    background_next    = background;
    flushing_next      = flushing;

    item_next          = '0;
    item_next.kind     = KIND_PROC;
    item_next.bg       = background;
    item_next.px       = raster.pixel_in;
    item_next.ic_zero  = (column_count == '0);
    item_next.in_range = (column_count < CNT_W'(MAX_WIDTH));
    item_next.row_ge1  = (row_count != '0);
    item_next.row_ge2  = row_count[1];

    if (accept) begin
      if (flushing) begin
        item_next.valid = 1'b1;
        if (column_count < learned_width) begin
          // flush column: background stands in for the missing lower row
          item_next.px      = background;
          column_count_next = column_count + 1'b1;
        end else begin
          item_next.kind    = KIND_FINAL;
          background_next   = background ? table_ends[1] : table_ends[0];
          column_count_next = '0;
          row_count_next    = '0;
          flushing_next     = 1'b0;
        end
      end else if (!raster.op) begin
        item_next.valid = 1'b1;
        if (raster.row_end || raster.frame_end) begin
          learned_width_next = column_count + 1'b1;
          row_count_next     = row_count[1] ? row_count : row_count + 1'b1;
          column_count_next  = '0;
          if (raster.frame_end) begin
            flushing_next = 1'b1;
          end
        end else if (column_count < COUNT_CAP) begin
          column_count_next = column_count + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count  <= '0;
      learned_width <= '0;
      row_count     <= '0;
      background    <= 1'b0;
      flushing      <= 1'b0;
      clearing      <= 1'b1;
      clr_addr      <= '0;
      item          <= '0;
      fwd           <= 1'b0;
    end else begin
      column_count  <= column_count_next;
      learned_width <= learned_width_next;
      row_count     <= row_count_next;
      background    <= background_next;
      flushing      <= flushing_next;
      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(MAX_WIDTH - 1)) begin
          clearing <= 1'b0;
        end
      end
      if (advance) begin
        item <= item_next;
      end
      if (accept) begin
        // write in flight to the entry being read: take its data instead
        fwd <= line_wr.en && (b_addr == ram_raddr);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr   <= ram_raddr;
      fwd_data <= line_wr.data;
    end
  end

endmodule

// ===== design/b3lwf_window.sv =====
// ----------------------------------------------------------------------------
// b3lwf_window: 3x3 window, table lookup, lit count and result register
// Builds the column from line data, updates the window, writes lines back.
// ----------------------------------------------------------------------------
module b3lwf_window (
  input  logic                              clk,
  input  logic                              rst,
  input  b3lwf_pkg::item_t                  item,
  input  logic [b3lwf_pkg::LINE_W-1:0]      line_data,
  input  logic [b3lwf_pkg::TABLE_SIZE-1:0]  lut,
  output logic                              advance,
  output b3lwf_pkg::line_wr_t               line_wr,
  b3lwf_result_if.source                    result
);
  import b3lwf_pkg::*;

  logic [IDX_W-1:0]      window, window_next;
  logic [ON_COUNT_W-1:0] lit_total, lit_next;
  logic [IDX_W-1:0]      emit_idx;
  logic                  emit;
  logic                  bit_out;
  logic                  top, mid;
  logic [2:0]            col, bg_col;
  logic                  last;

  assign advance = !result.valid || result.ready;

  always_comb begin
    top    = (item.in_range && item.row_ge2) ? line_data[1] : item.bg;
    mid    = (item.in_range && item.row_ge1) ? line_data[0] : item.bg;
    col    = {top, mid, item.px};
    bg_col = {3{item.bg}};
    last   = 1'b0;

    if (item.kind == KIND_FINAL) begin
      emit_idx    = shift_col(window, bg_col);
      emit        = 1'b1;
      last        = 1'b1;
      window_next = '0;
    end else if (item.ic_zero) begin
      // new row: close the previous row's last pixel, restart from background
      emit_idx    = shift_col(window, bg_col);
      emit        = item.row_ge2;
      window_next = shift_col({IDX_W{item.bg}}, col);
    end else begin
      window_next = shift_col(window, col);
      emit_idx    = window_next;
      emit        = item.row_ge1;
    end

    bit_out  = lut[emit_idx];
    lit_next = (bit_out && (lit_total < LIT_CAP)) ? lit_total + 1'b1 : lit_total;

    line_wr.en   = item.valid && advance && (item.kind == KIND_PROC) && item.in_range;
    line_wr.data = {mid, item.px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      window       <= '0;
      lit_total    <= '0;
      result.valid <= 1'b0;
    end else if (advance) begin
      result.valid <= item.valid && emit;
      if (item.valid) begin
        window <= window_next;
        if (emit) begin
          lit_total <= last ? '0 : lit_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && item.valid && emit) begin
      result.pixel_out  <= bit_out;
      result.on_count   <= lit_next;
      result.frame_last <= last;
    end
  end

endmodule

// ===== design/binary_3x3_lut_window_filter_top.sv =====
// ----------------------------------------------------------------------------
// binary_3x3_lut_window_filter_top: 3x3 lookup-table filter on a 1-bit raster
// Line RAM, raster control, window datapath and APB table registers.
// ----------------------------------------------------------------------------
// Takes one raster beat per clock unless results stall, returns one filtered
// pixel per pixel, lagging by width+1 beats, so each frame is followed by
// width+1 flush beats (op=1 while not flushing is dropped; any beat while
// flushing acts as flush). An accepted beat passes through the line RAM
// read and the item register, then the window/lookup stage into the result
// register. The 3x3 index has the top-left pixel as bit 8; outside the
// frame the background bit is used, and at frame end the background
// becomes table[background ? 511 : 0]. on_count counts lit results in the
// frame and saturates; frame_last marks the frame's final result. Rows
// beyond MAX_WIDTH columns are not buffered there (reads give the background).
// After reset the line RAM is cleared entry by entry; no beat is taken
// during that pass, table writes are. Write the table only while idle.
// ----------------------------------------------------------------------------
module binary_3x3_lut_window_filter_top #(
  parameter int MAX_WIDTH = b3lwf_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic                              clk,
  input  logic                              rst,
  b3lwf_raster_if.sink                      raster,
  b3lwf_result_if.source                    result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [b3lwf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [b3lwf_pkg::WORD_W-1:0]      pwdata,
  output logic [b3lwf_pkg::WORD_W-1:0]      prdata,
  output logic                              pready
);
  import b3lwf_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);

  logic [TABLE_SIZE-1:0] lut;
  logic                  advance;
  line_wr_t              line_wr;
  item_t                 item;
  logic [LINE_W-1:0]     line_data;

  // line RAM port
  logic                  ram_re, ram_we;
  logic [AW-1:0]         ram_raddr, ram_waddr;
  logic [LINE_W-1:0]     ram_wdata, ram_rdata;

  b3lwf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .lut     (lut)
  );

  // upper and middle line share one entry per column
  b3lwf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  b3lwf_ctrl #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .raster     (raster),
    .table_ends ({lut[TABLE_SIZE-1], lut[0]}),
    .advance    (advance),
    .line_wr    (line_wr),
    .ram_rdata  (ram_rdata),
    .ram_re     (ram_re),
    .ram_raddr  (ram_raddr),
    .ram_we     (ram_we),
    .ram_waddr  (ram_waddr),
    .ram_wdata  (ram_wdata),
    .item       (item),
    .line_data  (line_data)
  );

  b3lwf_window u_window (
    .clk       (clk),
    .rst       (rst),
    .item      (item),
    .line_data (line_data),
    .lut       (lut),
    .advance   (advance),
    .line_wr   (line_wr),
    .result    (result)
  );

endmodule
